[hw/rtl/bcd_pkg.sv]
`default_nettype none

package bcd_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 13;                          // configured width / height
    localparam int COL_W   = $clog2(MAX_WIDTH);           // column counter
    localparam int ROW_W   = $clog2(MAX_HEIGHT);          // row counter
    localparam int CELL_W  = 11;                          // cell row / column output
    localparam int HADDR_W = $clog2(MAX_WIDTH / 2);       // one line store bank
    localparam int CIDX_W  = 2;

    localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CFA_PATTERN  = 2'd2;

    // Filter layouts
    localparam logic [1:0] CFA_RGGB = 2'd0;
    localparam logic [1:0] CFA_GRBG = 2'd1;
    localparam logic [1:0] CFA_GBRG = 2'd2;
    localparam logic [1:0] CFA_BGGR = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [1:0]       pattern;
    } t_cfg;

    // Cell request issued with the line store read
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic [PIX_W-1:0]  bot_left;
        logic [PIX_W-1:0]  bot_right;
        logic              last;
    } t_cell_req;

endpackage

`default_nettype wire

[hw/rtl/bcd_line_store.sv]
`default_nettype none

// Two banks: even and odd columns of the last even row.
module bcd_line_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_even,
    input  wire logic                         i_wr_odd,
    input  wire logic [bcd_pkg::HADDR_W-1:0]  i_wr_addr,
    input  wire logic [bcd_pkg::PIX_W-1:0]    i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [bcd_pkg::HADDR_W-1:0]  i_rd_addr,
    output logic      [bcd_pkg::PIX_W-1:0]    o_rd_even,
    output logic      [bcd_pkg::PIX_W-1:0]    o_rd_odd
);

    logic [bcd_pkg::PIX_W-1:0] mem_even [bcd_pkg::MAX_WIDTH/2];
    logic [bcd_pkg::PIX_W-1:0] mem_odd  [bcd_pkg::MAX_WIDTH/2];

    always_ff @(posedge i_clk) begin
        if (i_wr_even) begin
            mem_even[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_even <= mem_even[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_odd) begin
            mem_odd[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_odd <= mem_odd[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bcd_scan.sv]
`default_nettype none

// Config registers, raster counters, held pixel, line store write/read control.
module bcd_scan (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bcd_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [bcd_pkg::DIM_W-1:0]    i_cfg_data,
    input  wire logic                         i_accept,
    input  wire logic [bcd_pkg::PIX_W-1:0]    i_pixel,
    output logic      [1:0]                   o_pattern,
    output logic                              o_wr_even,
    output logic                              o_wr_odd,
    output logic      [bcd_pkg::HADDR_W-1:0]  o_addr,
    output bcd_pkg::t_cell_req                o_req
);

    bcd_pkg::t_cfg                r_cfg;
    logic [bcd_pkg::COL_W-1:0]    r_col, n_col;
    logic [bcd_pkg::ROW_W-1:0]    r_row, n_row;
    logic [bcd_pkg::PIX_W-1:0]    r_held;

    logic [bcd_pkg::DIM_W-1:0]    w_eff, h_eff;
    logic [bcd_pkg::DIM_W-1:0]    col_x, row_x, col_inc, row_inc;
    logic                         in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= 13'd640;
            r_cfg.height  <= 13'd480;
            r_cfg.pattern <= bcd_pkg::CFA_RGGB;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bcd_pkg::CFG_IMAGE_WIDTH:  r_cfg.width   <= i_cfg_data;
                bcd_pkg::CFG_IMAGE_HEIGHT: r_cfg.height  <= i_cfg_data;
                bcd_pkg::CFG_CFA_PATTERN:  r_cfg.pattern <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff    = (r_cfg.width  > bcd_pkg::MAX_WIDTH_D)  ? bcd_pkg::MAX_WIDTH_D  : r_cfg.width;
        h_eff    = (r_cfg.height > bcd_pkg::MAX_HEIGHT_D) ? bcd_pkg::MAX_HEIGHT_D : r_cfg.height;
        col_x    = bcd_pkg::DIM_W'(r_col);
        row_x    = bcd_pkg::DIM_W'(r_row);
        col_inc  = col_x + 1'b1;
        row_inc  = row_x + 1'b1;
        in_frame = (col_x < w_eff) && (row_x < h_eff);

        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[bcd_pkg::ROW_W-1:0];
        end else begin
            n_col = col_inc[bcd_pkg::COL_W-1:0];
            n_row = r_row;
        end

        o_wr_even = i_accept && in_frame && !r_row[0] && !r_col[0];
        o_wr_odd  = i_accept && in_frame && !r_row[0] &&  r_col[0];
        o_addr    = r_col[bcd_pkg::COL_W-1:1];

        o_req.valid     = i_accept && in_frame && r_row[0] && r_col[0];
        o_req.row       = bcd_pkg::CELL_W'(r_row[bcd_pkg::ROW_W-1:1]);
        o_req.col       = bcd_pkg::CELL_W'(r_col[bcd_pkg::COL_W-1:1]);
        o_req.bot_left  = r_held;
        o_req.bot_right = i_pixel;
        // heights/widths below two give all ones here, which never matches
        o_req.last      = (row_x == ((h_eff & ~bcd_pkg::DIM_W'(1)) - 1'b1))
                       && (col_x == ((w_eff & ~bcd_pkg::DIM_W'(1)) - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_frame && r_row[0] && !r_col[0]) begin
                r_held <= i_pixel;
            end
        end
    end

    assign o_pattern = r_cfg.pattern;

endmodule

`default_nettype wire

[hw/rtl/bcd_cell_out.sv]
`default_nettype none

// Cell stage (aligned with line store read data) and output register.
module bcd_cell_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bcd_pkg::t_cell_req          i_req,
    input  wire logic [1:0]                  i_pattern,
    input  wire logic [bcd_pkg::PIX_W-1:0]   i_top_left,
    input  wire logic [bcd_pkg::PIX_W-1:0]   i_top_right,
    input  wire logic                        i_out_stall,
    output logic                             o_free,
    output logic                             o_out_valid,
    output logic      [bcd_pkg::CELL_W-1:0]  o_cell_row,
    output logic      [bcd_pkg::CELL_W-1:0]  o_cell_col,
    output logic      [bcd_pkg::PIX_W-1:0]   o_red,
    output logic      [bcd_pkg::PIX_W-1:0]   o_green,
    output logic      [bcd_pkg::PIX_W-1:0]   o_blue,
    output logic                             o_frame_last
);

    bcd_pkg::t_cell_req        r_s1;
    logic                      r_ov;
    logic                      adv_out;
    logic [bcd_pkg::PIX_W-1:0] red, blue, g_a, g_b;
    logic [bcd_pkg::PIX_W:0]   g_sum;

    assign adv_out = !r_ov || !i_out_stall;
    assign o_free  = !r_s1.valid || adv_out;

    always_comb begin
        case (i_pattern)
            bcd_pkg::CFA_RGGB: begin
                red = i_top_left;      blue = r_s1.bot_right;
                g_a = i_top_right;     g_b  = r_s1.bot_left;
            end
            bcd_pkg::CFA_GRBG: begin
                red = i_top_right;     blue = r_s1.bot_left;
                g_a = i_top_left;      g_b  = r_s1.bot_right;
            end
            bcd_pkg::CFA_GBRG: begin
                red = r_s1.bot_left;   blue = i_top_right;
                g_a = i_top_left;      g_b  = r_s1.bot_right;
            end
            default: begin
                red = r_s1.bot_right;  blue = i_top_left;
                g_a = i_top_right;     g_b  = r_s1.bot_left;
            end
        endcase
        g_sum = {1'b0, g_a} + {1'b0, g_b} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (o_free) begin
                r_s1.valid <= i_req.valid;
            end
            if (o_free && i_req.valid) begin
                r_s1.row       <= i_req.row;
                r_s1.col       <= i_req.col;
                r_s1.bot_left  <= i_req.bot_left;
                r_s1.bot_right <= i_req.bot_right;
                r_s1.last      <= i_req.last;
            end
            if (adv_out) begin
                r_ov <= r_s1.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1.valid) begin
            o_cell_row   <= r_s1.row;
            o_cell_col   <= r_s1.col;
            o_red        <= red;
            o_green      <= g_sum[bcd_pkg::PIX_W:1];
            o_blue       <= blue;
            o_frame_last <= r_s1.last;
        end
    end

    assign o_out_valid = r_ov;

endmodule

`default_nettype wire

[hw/rtl/bayer_cell_demosaic.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// ------    ---------  ---------------------  -------------------------------------------
// in        sink       i_in_valid/o_in_stall  i_raw_pixel
// out       source     o_out_valid/i_out_stall o_cell_row o_cell_col o_red o_green o_blue
//                                              o_frame_last
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// One pixel item per clock while o_in_stall is low. A cell result passes
// the cell stage, registered with the line store read, then the output
// register. Reset (synchronous, active low) clears counters, held pixel
// and valids and loads the default config; the line store is not cleared.
// o_in_stall rises only while both the cell stage and the output register
// are full and the output is stalled. Config writes are always taken.
module bayer_cell_demosaic (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel input
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [bcd_pkg::PIX_W-1:0]   i_raw_pixel,
    // cell output
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [bcd_pkg::CELL_W-1:0]  o_cell_row,
    output logic      [bcd_pkg::CELL_W-1:0]  o_cell_col,
    output logic      [bcd_pkg::PIX_W-1:0]   o_red,
    output logic      [bcd_pkg::PIX_W-1:0]   o_green,
    output logic      [bcd_pkg::PIX_W-1:0]   o_blue,
    output logic                             o_frame_last,
    // configuration
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bcd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [bcd_pkg::DIM_W-1:0]   i_cfg_data
);

    logic [1:0]                  pattern;
    bcd_pkg::t_cell_req          req;
    logic                        accept, free;
    logic                        wr_even, wr_odd;
    logic [bcd_pkg::HADDR_W-1:0] addr;
    logic [bcd_pkg::PIX_W-1:0]   top_left, top_right;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !free;
    assign accept      = i_in_valid && free;

    // counters, config and line store control
    bcd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_raw_pixel),
        .o_pattern   (pattern),
        .o_wr_even   (wr_even),
        .o_wr_odd    (wr_odd),
        .o_addr      (addr),
        .o_req       (req)
    );

    // even-row pixels; read on the cell-completing pixel
    bcd_line_store u_store (
        .i_clk     (i_clk),
        .i_wr_even (wr_even),
        .i_wr_odd  (wr_odd),
        .i_wr_addr (addr),
        .i_wr_data (i_raw_pixel),
        .i_rd_en   (req.valid),
        .i_rd_addr (addr),
        .o_rd_even (top_left),
        .o_rd_odd  (top_right)
    );

    // color selection, green average, output register
    bcd_cell_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_pattern    (pattern),
        .i_top_left   (top_left),
        .i_top_right  (top_right),
        .i_out_stall  (i_out_stall),
        .o_free       (free),
        .o_out_valid  (o_out_valid),
        .o_cell_row   (o_cell_row),
        .o_cell_col   (o_cell_col),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

[hw/rtl/bcd_checker.sv]
`default_nettype none

module bcd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [bcd_pkg::CELL_W-1:0]  o_cell_row,
    input wire logic [bcd_pkg::CELL_W-1:0]  o_cell_col,
    input wire logic [bcd_pkg::PIX_W-1:0]   o_red,
    input wire logic [bcd_pkg::PIX_W-1:0]   o_green,
    input wire logic [bcd_pkg::PIX_W-1:0]   o_blue,
    input wire logic                        o_frame_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_cell_row, o_cell_col, o_red, o_green, o_blue, o_frame_last}))
        else $error("output item changed while stalled");

    // input backpressure only when the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a fresh result is preceded by an accepted pixel
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a source pixel");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind bayer_cell_demosaic bcd_checker u_bcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_cell_row   (o_cell_row),
    .o_cell_col   (o_cell_col),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_frame_last (o_frame_last)
);

`default_nettype wire

[test/bayer_cell_demosaic_tb.sv]
`timescale 1ns / 100ps

module bayer_cell_demosaic_tb;

    // index past the end of the register list, must be ignored
    localparam logic [bcd_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 650;
    localparam int DRAIN_CYCLES   = 8;     // cell passes the cell stage and output register after its pixel
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int REPORT_CAP     = 100;

    // one cell result, field per output port
    typedef struct packed {
        logic [bcd_pkg::CELL_W-1:0] row;
        logic [bcd_pkg::CELL_W-1:0] col;
        logic [bcd_pkg::PIX_W-1:0]  red;
        logic [bcd_pkg::PIX_W-1:0]  green;
        logic [bcd_pkg::PIX_W-1:0]  blue;
        logic                       last;
    } t_cell;

    // Demosaic predictor plus the queue of cells still owed by the block.
    class t_cell_scoreboard;
        logic [bcd_pkg::DIM_W-1:0] width;
        logic [bcd_pkg::DIM_W-1:0] height;
        logic [1:0]                pattern;
        logic [bcd_pkg::PIX_W-1:0] line_mem [bcd_pkg::MAX_WIDTH];
        logic [bcd_pkg::PIX_W-1:0] held;
        logic [bcd_pkg::COL_W-1:0] col_cnt;
        logic [bcd_pkg::ROW_W-1:0] row_cnt;
        t_cell                     cells_due [$];
        int                        errors;

        function new();
            width   = 13'd640;
            height  = 13'd480;
            pattern = bcd_pkg::CFA_RGGB;
            held    = '0;
            col_cnt = '0;
            row_cnt = '0;
            errors  = 0;
            foreach (line_mem[i]) line_mem[i] = '0;
        endfunction

        function void apply_reg(logic [bcd_pkg::CIDX_W-1:0] idx,
                                logic [bcd_pkg::DIM_W-1:0] data);
            case (idx)
                bcd_pkg::CFG_IMAGE_WIDTH:  width   = data;
                bcd_pkg::CFG_IMAGE_HEIGHT: height  = data;
                bcd_pkg::CFG_CFA_PATTERN:  pattern = data[1:0];
                default: ;
            endcase
        endfunction

        function bit at_frame_start();
            return col_cnt == '0 && row_cnt == '0;
        endfunction

        // Accepted pixel: update line store / held pixel / counters,
        // queue a cell when the pixel closes one.
        function void note_pixel(logic [bcd_pkg::PIX_W-1:0] px);
            logic [bcd_pkg::DIM_W-1:0] w;
            logic [bcd_pkg::DIM_W-1:0] h;
            logic [bcd_pkg::DIM_W-1:0] col;
            logic [bcd_pkg::DIM_W-1:0] row;
            logic [bcd_pkg::PIX_W-1:0] quad [4];
            int                        r_at;
            int                        b_at;
            int                        g_a;
            int                        g_b;
            t_cell                     c;
            w   = (width > bcd_pkg::MAX_WIDTH_D) ? bcd_pkg::MAX_WIDTH_D : width;
            h   = (height > bcd_pkg::MAX_HEIGHT_D) ? bcd_pkg::MAX_HEIGHT_D : height;
            col = bcd_pkg::DIM_W'(col_cnt);
            row = bcd_pkg::DIM_W'(row_cnt);
            if (col < w && row < h) begin
                if (!row[0]) begin
                    line_mem[col] = px;
                end else if (!col[0]) begin
                    held = px;
                end else begin
                    // 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
                    quad[0] = line_mem[col - 1];
                    quad[1] = line_mem[col];
                    quad[2] = held;
                    quad[3] = px;
                    case (pattern)
                        bcd_pkg::CFA_RGGB: begin r_at = 0; b_at = 3; g_a = 1; g_b = 2; end
                        bcd_pkg::CFA_GRBG: begin r_at = 1; b_at = 2; g_a = 0; g_b = 3; end
                        bcd_pkg::CFA_GBRG: begin r_at = 2; b_at = 1; g_a = 0; g_b = 3; end
                        default:           begin r_at = 3; b_at = 0; g_a = 1; g_b = 2; end
                    endcase
                    c.row   = bcd_pkg::CELL_W'(row >> 1);
                    c.col   = bcd_pkg::CELL_W'(col >> 1);
                    c.red   = quad[r_at];
                    c.blue  = quad[b_at];
                    c.green = bcd_pkg::PIX_W'(({1'b0, quad[g_a]} + {1'b0, quad[g_b]}
                                               + 9'd1) >> 1);
                    c.last  = (32'(row) == (32'(h) & ~32'd1) - 32'd1) &&
                              (32'(col) == (32'(w) & ~32'd1) - 32'd1);
                    cells_due.push_back(c);
                end
            end
            if (32'(col) + 32'd1 >= 32'(w)) begin
                col_cnt = '0;
                row_cnt = (32'(row) + 32'd1 >= 32'(h)) ? '0 : bcd_pkg::ROW_W'(row + 1);
            end else begin
                col_cnt = bcd_pkg::COL_W'(col + 1);
            end
        endfunction

        task report_mismatch(string what);
            if (errors < REPORT_CAP) $display("mismatch: %s", what);
            errors++;
        endtask

        task compare_field(string name, int got, int want, t_cell ref_cell);
            if (got != want) begin
                report_mismatch($sformatf("cell r%0d c%0d %s got %0d want %0d",
                    ref_cell.row, ref_cell.col, name, got, want));
            end
        endtask

        task check_cell(t_cell got);
            t_cell want;
            if (cells_due.size() == 0) begin
                report_mismatch($sformatf("unexpected cell r%0d c%0d", got.row, got.col));
            end else begin
                want = cells_due.pop_front();
                compare_field("cell_row",   got.row,   want.row,   want);
                compare_field("cell_col",   got.col,   want.col,   want);
                compare_field("red",        got.red,   want.red,   want);
                compare_field("green",      got.green, want.green, want);
                compare_field("blue",       got.blue,  want.blue,  want);
                compare_field("frame_last", got.last,  want.last,  want);
            end
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [bcd_pkg::PIX_W-1:0]   i_raw_pixel = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [bcd_pkg::CELL_W-1:0]  o_cell_row;
    logic [bcd_pkg::CELL_W-1:0]  o_cell_col;
    logic [bcd_pkg::PIX_W-1:0]   o_red;
    logic [bcd_pkg::PIX_W-1:0]   o_green;
    logic [bcd_pkg::PIX_W-1:0]   o_blue;
    logic                        o_frame_last;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [bcd_pkg::CIDX_W-1:0]  i_cfg_index = '0;
    logic [bcd_pkg::DIM_W-1:0]   i_cfg_data = '0;

    t_cell_scoreboard    sb;
    bit                  no_idle = 1'b0;   // suppresses gaps and stalls on both sides
    int                  pixels_sent = 0;
    int                  stuck_cycles = 0;

    bayer_cell_demosaic i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_pixel  (i_raw_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_row   (o_cell_row),
        .o_cell_col   (o_cell_col),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output back-pressure: ~15% stall unless in the no-idle stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 15);
    end

    // Cell monitor. Sampled in the active region, so these are the values
    // the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_cell('{o_cell_row, o_cell_col, o_red, o_green, o_blue, o_frame_last});
        end
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("bayer_cell_demosaic_tb: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [bcd_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return bcd_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One pixel item; random gap first, then hold until not stalled.
    task automatic send_pixel(input logic [bcd_pkg::PIX_W-1:0] px);
        while (!no_idle && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_pixel <= px;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    // 2x2 frame (width 2): top row then bottom row
    task automatic send_cell(input logic [bcd_pkg::PIX_W-1:0] tl, tr, bl, br);
        send_pixel(tl);
        send_pixel(tr);
        send_pixel(bl);
        send_pixel(br);
    endtask

    // Random pixels until the counters wrap back to row 0 column 0.
    task automatic run_to_frame_start();
        do send_pixel(rand_pixel()); while (!sb.at_frame_start());
    endtask

    // Stop input, let every owed cell out, then keep idling in case
    // the last pixels were still in flight without producing a cell.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.cells_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high; caller lowers it after the last write.
    task automatic write_reg(input logic [bcd_pkg::CIDX_W-1:0] idx,
                             input logic [bcd_pkg::DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg(idx, data);
    endtask

    task automatic program_geometry(input logic [bcd_pkg::DIM_W-1:0] w, h,
                                    input logic [1:0] pat, input bit spare);
        wait_drained();
        write_reg(bcd_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bcd_pkg::CFG_IMAGE_HEIGHT, h);
        // junk in the unused upper bits of the pattern write
        write_reg(bcd_pkg::CFG_CFA_PATTERN, {11'($urandom_range(0, 2047)), pat});
        if (spare) write_reg(CFG_SPARE, bcd_pkg::DIM_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                        directed_pixels;
        int                        frames;
        logic [bcd_pkg::DIM_W-1:0] w;
        logic [bcd_pkg::DIM_W-1:0] h;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // pattern left at its reset value (rggb)
        write_reg(bcd_pkg::CFG_IMAGE_WIDTH, 13'd2);
        write_reg(bcd_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        i_cfg_valid <= 1'b0;
        send_cell(8'd0, 8'd255, 8'd255, 8'd0);     // green sum at maximum
        send_cell(8'd255, 8'd0, 8'd0, 8'd255);
        send_cell(8'd10, 8'd3, 8'd4, 8'd20);       // odd green sum rounds up

        // remaining layouts, distinct values so misplaced samples show
        program_geometry(13'd2, 13'd2, bcd_pkg::CFA_GRBG, 1'b1);
        send_cell(8'd11, 8'd22, 8'd33, 8'd44);
        program_geometry(13'd2, 13'd2, bcd_pkg::CFA_GBRG, 1'b0);
        send_cell(8'd11, 8'd22, 8'd33, 8'd44);
        program_geometry(13'd2, 13'd2, bcd_pkg::CFA_BGGR, 1'b0);
        send_cell(8'd11, 8'd22, 8'd33, 8'd44);

        // width one / zero: counters wrap, no cells
        program_geometry(13'd1, 13'd3, bcd_pkg::CFA_RGGB, 1'b0);
        run_to_frame_start();
        program_geometry(13'd0, 13'd0, bcd_pkg::CFA_RGGB, 1'b0);
        run_to_frame_start();
        run_to_frame_start();

        // width shrunk mid-frame: stop at row 1 column 4 of an 8x4 frame,
        // then width 2 -> the next pixel is dropped and the row wraps
        program_geometry(13'd8, 13'd4, bcd_pkg::CFA_RGGB, 1'b0);
        repeat (12) send_pixel(rand_pixel());
        wait_drained();
        write_reg(bcd_pkg::CFG_IMAGE_WIDTH, 13'd2);
        i_cfg_valid <= 1'b0;
        run_to_frame_start();

        // --- random phases, small geometry ---
        directed_pixels = pixels_sent;
        while (pixels_sent - directed_pixels < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) w = bcd_pkg::DIM_W'($urandom_range(0, 1));
            else if ($urandom_range(0, 3) == 0) w = bcd_pkg::DIM_W'($urandom_range(13, 40));
            else w = bcd_pkg::DIM_W'($urandom_range(2, 12));
            if ($urandom_range(0, 19) == 0) h = bcd_pkg::DIM_W'($urandom_range(0, 1));
            else h = bcd_pkg::DIM_W'($urandom_range(2, 8));
            program_geometry(w, h, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
            // one long stretch with no gaps or stalls
            no_idle = (pixels_sent - directed_pixels >= 300) &&
                      (pixels_sent - directed_pixels < 480);
            frames = $urandom_range(1, 2);
            repeat (frames) run_to_frame_start();
        end
        no_idle = 1'b0;

        // --- saturated extremes: widest row, tallest frame, each cut short
        // by shrinking the geometry so the counters wrap early ---
        program_geometry(13'd8191, 13'd2, 2'($urandom_range(0, 3)), 1'b0);
        repeat (64) send_pixel(rand_pixel());
        wait_drained();
        write_reg(bcd_pkg::CFG_IMAGE_WIDTH, 13'd2);
        i_cfg_valid <= 1'b0;
        run_to_frame_start();
        program_geometry(13'd2, 13'd8191, 2'($urandom_range(0, 3)), 1'b0);
        repeat (40) send_pixel(rand_pixel());
        wait_drained();
        write_reg(bcd_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        i_cfg_valid <= 1'b0;
        run_to_frame_start();

        wait_drained();
        if (sb.errors == 0) begin
            $display("bayer_cell_demosaic_tb: clean");
        end else begin
            $display("bayer_cell_demosaic_tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_line_store.sv
hw/rtl/bcd_scan.sv
hw/rtl/bcd_cell_out.sv
hw/rtl/bayer_cell_demosaic.sv
hw/rtl/bcd_checker.sv
test/bayer_cell_demosaic_tb.sv
